/* design/ffde_pkg.sv */
// Package for the flood forwarding engine with duplicate suppression.
// Holds the table sizes, beat layouts, register indexes and the
// controller/datapath interface structs. Depends on nothing.
package ffde_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int ADDRESS_BITS  = 16;
  localparam int SEQUENCE_BITS = 16;
  localparam int TTL_BITS      = 8;
  localparam int COUNT_BITS    = 32;
  localparam int CFG_BITS      = (ADDRESS_BITS > TTL_BITS) ? ADDRESS_BITS : TTL_BITS;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int PAIR_W  = ADDRESS_BITS + SEQUENCE_BITS;

  localparam logic [TTL_BITS-1:0] RESET_TTL = TTL_BITS'(6);
  localparam logic [TTL_BITS-1:0] TTL_ONE   = TTL_BITS'(1);

  // Operation codes carried in the input tuser.
  localparam logic OP_LOCAL_SEND = 1'b0;
  localparam logic OP_RECEIVE    = 1'b1;

  // Configuration register indexes.
  localparam logic REG_NODE_ADDRESS = 1'b0;
  localparam logic REG_DEFAULT_TTL  = 1'b1;

  localparam int IN_RAW_W  = ADDRESS_BITS + SEQUENCE_BITS + TTL_BITS;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
  localparam int IN_PAD_W  = (IN_DATA_W > IN_RAW_W) ? IN_DATA_W - IN_RAW_W : 1;

  localparam int OUT_RAW_W  = 3 + 2 * ADDRESS_BITS + SEQUENCE_BITS + 3 * TTL_BITS
                              + 3 * COUNT_BITS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = (OUT_DATA_W > OUT_RAW_W) ? OUT_DATA_W - OUT_RAW_W : 1;

  // Members are listed from the highest bits down.
  typedef struct packed {
    logic [IN_PAD_W-1:0]      pad;
    logic [TTL_BITS-1:0]      in_hops_left;
    logic [SEQUENCE_BITS-1:0] in_sequence;
    logic [ADDRESS_BITS-1:0]  in_source;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0]     pad;
    logic [COUNT_BITS-1:0]    forwarded_count;
    logic [COUNT_BITS-1:0]    delivered_count;
    logic [COUNT_BITS-1:0]    hop_total;
    logic [TTL_BITS-1:0]      max_hops_seen;
    logic [TTL_BITS-1:0]      hops_taken;
    logic [ADDRESS_BITS-1:0]  out_forwarder;
    logic [TTL_BITS-1:0]      out_hops_left;
    logic [SEQUENCE_BITS-1:0] out_sequence;
    logic [ADDRESS_BITS-1:0]  out_source;
    logic                     was_duplicate;
    logic                     deliver_up;
    logic                     send_down;
  } out_beat_t;

  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_en;
    logic             commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_send;
    logic out_full;
  } dp_status_t;

endpackage

/* design/ffde_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Self-contained.
module ffde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ffde_ctrl.sv */
// Controller for the flood forwarding engine: sequences capture, table
// scan and commit. Depends on ffde_pkg.
module ffde_ctrl
  import ffde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.rd_en   = (state_q == ST_SCAN) && (cnt_q < CNT_W'(TABLE_DEPTH));
    cmd_o.rd_addr = cnt_q[IDX_W-1:0];
    // Read data for entry cnt-1 arrives while entry cnt is being addressed.
    cmd_o.cmp_en  = (state_q == ST_SCAN) && (cnt_q != '0);
    cmd_o.commit  = (state_q == ST_FINISH) && !status_i.out_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (s_tvalid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if ((cnt_q == '0 && status_i.is_send) || cnt_q == CNT_W'(TABLE_DEPTH)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!status_i.out_full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/ffde_datapath.sv */
// Datapath for the flood forwarding engine: configuration, item registers,
// seen-pair table, statistics and output register. Depends on ffde_pkg, ffde_ram.
module ffde_datapath
  import ffde_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_BITS-1:0]      cfg_wdata_i,
  input  logic                     s_tuser_i,
  input  logic [IN_DATA_W-1:0]     s_tdata_i,
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [OUT_DATA_W-1:0]    m_tdata_o,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o
);

  logic [ADDRESS_BITS-1:0]  node_address_q;
  logic [TTL_BITS-1:0]      default_ttl_q;

  logic                     op_q;
  logic [ADDRESS_BITS-1:0]  src_q;
  logic [SEQUENCE_BITS-1:0] seq_q;
  logic [TTL_BITS-1:0]      ttl_q;

  logic [TABLE_DEPTH-1:0]   entry_valid_q;
  logic [IDX_W-1:0]         insert_ptr_q;
  logic [SEQUENCE_BITS-1:0] own_seq_q;
  logic [COUNT_BITS-1:0]    hop_sum_q;
  logic [TTL_BITS-1:0]      hop_max_q;
  logic [COUNT_BITS-1:0]    delivered_q;
  logic [COUNT_BITS-1:0]    forwarded_q;

  logic                     rd_valid_q;
  logic                     hit_q;
  logic                     out_valid_q;
  out_beat_t                result_q;

  logic [PAIR_W-1:0]        rdata;
  in_beat_t                 in_beat;

  logic                     is_send;
  logic                     new_pair;
  logic                     forward;
  logic [ADDRESS_BITS-1:0]  pair_src;
  logic [SEQUENCE_BITS-1:0] pair_seq;
  logic [TTL_BITS-1:0]      hops;
  logic [TTL_BITS-1:0]      o_ttl;
  logic [COUNT_BITS-1:0]    hop_sum_d;
  logic [TTL_BITS-1:0]      hop_max_d;
  logic [COUNT_BITS-1:0]    delivered_d;
  logic [COUNT_BITS-1:0]    forwarded_d;
  out_beat_t                result_d;

  assign in_beat = in_beat_t'(s_tdata_i);

  ffde_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && new_pair),
    .waddr_i (insert_ptr_q),
    .wdata_i ({pair_src, pair_seq}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    is_send  = (op_q == OP_LOCAL_SEND);
    new_pair = is_send || !hit_q;
    forward  = !is_send && (ttl_q > TTL_ONE);
    pair_src = is_send ? node_address_q : src_q;
    pair_seq = is_send ? own_seq_q : seq_q;
    hops     = (!is_send && default_ttl_q > ttl_q) ? default_ttl_q - ttl_q : '0;

    if (is_send) begin
      o_ttl = default_ttl_q;
    end else if (forward) begin
      o_ttl = ttl_q - TTL_ONE;
    end else begin
      o_ttl = ttl_q;
    end

    hop_sum_d   = hop_sum_q;
    hop_max_d   = hop_max_q;
    delivered_d = delivered_q;
    forwarded_d = forwarded_q;
    if (!is_send && !hit_q) begin
      hop_sum_d   = hop_sum_q + COUNT_BITS'(hops);
      hop_max_d   = (hops > hop_max_q) ? hops : hop_max_q;
      delivered_d = delivered_q + COUNT_BITS'(1);
    end
    if (forward) begin
      forwarded_d = forwarded_q + COUNT_BITS'(1);
    end

    result_d                 = '0;
    result_d.send_down       = is_send || forward;
    result_d.deliver_up      = !is_send && !hit_q;
    result_d.was_duplicate   = !is_send && hit_q;
    result_d.out_source      = pair_src;
    result_d.out_sequence    = pair_seq;
    result_d.out_hops_left   = o_ttl;
    result_d.out_forwarder   = node_address_q;
    result_d.hops_taken      = hops;
    result_d.max_hops_seen   = hop_max_d;
    result_d.hop_total       = hop_sum_d;
    result_d.delivered_count = delivered_d;
    result_d.forwarded_count = forwarded_d;
  end

  // Item registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= s_tuser_i;
      src_q <= in_beat.in_source;
      seq_q <= in_beat.in_sequence;
      ttl_q <= in_beat.in_hops_left;
    end
    if (cmd_i.commit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
      default_ttl_q  <= RESET_TTL;
      entry_valid_q  <= '0;
      insert_ptr_q   <= '0;
      own_seq_q      <= '0;
      hop_sum_q      <= '0;
      hop_max_q      <= '0;
      delivered_q    <= '0;
      forwarded_q    <= '0;
      rd_valid_q     <= 1'b0;
      hit_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NODE_ADDRESS: node_address_q <= cfg_wdata_i[ADDRESS_BITS-1:0];
          REG_DEFAULT_TTL:  default_ttl_q  <= cfg_wdata_i[TTL_BITS-1:0];
          default:          ;
        endcase
      end

      if (cmd_i.rd_en) begin
        rd_valid_q <= entry_valid_q[cmd_i.rd_addr];
      end

      if (cmd_i.capture) begin
        hit_q <= 1'b0;
      end else if (cmd_i.cmp_en && rd_valid_q && rdata == {src_q, seq_q}) begin
        hit_q <= 1'b1;
      end

      if (m_tready_i && !cmd_i.commit) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        hop_sum_q   <= hop_sum_d;
        hop_max_q   <= hop_max_d;
        delivered_q <= delivered_d;
        forwarded_q <= forwarded_d;
        if (is_send) begin
          own_seq_q <= own_seq_q + SEQUENCE_BITS'(1);
        end
        if (new_pair) begin
          entry_valid_q[insert_ptr_q] <= 1'b1;
          insert_ptr_q <= (insert_ptr_q == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                     : insert_ptr_q + IDX_W'(1);
        end
      end
    end
  end

  assign status_o.is_send  = is_send;
  assign status_o.out_full = out_valid_q && !m_tready_i;
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = OUT_DATA_W'(result_q);

endmodule

/* design/flood_forward_dedup_engine.sv */
// Top level of the flood forwarding engine with duplicate suppression.
// Depends on ffde_pkg, ffde_ctrl, ffde_datapath (and ffde_ram below it).
//
// Usage: the slave stream carries one packet event per beat. s_tuser_i is
// the operation (0 local send, 1 packet received from below); s_tdata_i holds
// in_source, in_sequence and in_hops_left. Every accepted beat yields exactly
// one beat on the master stream with the forwarding decision, the outgoing
// packet header and the statistics after the event. The plain write port sets
// node_address (index 0) and default_ttl (index 1); the user must write them
// only while the block is idle, as the block itself does not enforce this.
// A received packet occupies the block for a sequential scan of the seen-pair
// RAM through its single read port, one entry per cycle. A local send needs
// no lookup and ends the scan at its first step. After the scan, the finish
// step commits the result into an output register, where it is held.
// If the receiver stalls, the next event may still be accepted and scanned,
// and it waits in its final step until the output register is free.
// Reset clears the valid bits of the whole table at once, the insert
// pointer, own sequence number and all statistics; default_ttl returns to 6.
module flood_forward_dedup_engine
  import ffde_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_BITS-1:0]   cfg_wdata_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // operation
  input  logic                  s_tuser_i,
  // in_source, in_sequence, in_hops_left
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // send_down, deliver_up, was_duplicate, out_source, out_sequence,
  // out_hops_left, out_forwarder, hops_taken, max_hops_seen, hop_total,
  // delivered_count, forwarded_count, zero padding
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ffde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ffde_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* design/ffde_checker.sv */
// Port-level checker for the flood forwarding engine, bound to the top level.
// Depends on ffde_pkg.
module ffde_checker
  import ffde_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_o,
  input logic                  m_tvalid_o,
  input logic                  m_tready_i,
  input logic [OUT_DATA_W-1:0] m_tdata_o
);

  out_beat_t beat;
  assign beat = out_beat_t'(m_tdata_o);

  // Only one event is taken in at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("input accepted on two consecutive cycles");

  // A result is produced only from the final step, never while idle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(!s_tready_o))
    else $error("result appeared while the block was idle");

  // A duplicate is never delivered upward.
  a_no_dup_delivery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(beat.deliver_up && beat.was_duplicate))
    else $error("duplicate packet delivered upward");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("result beat changed while stalled");

endmodule

bind flood_forward_dedup_engine ffde_checker u_ffde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
